### sv/ccc_pkg.sv
// shared types, codes and report order for the coincidence cluster counter
`timescale 1ns / 1ps

package ccc_pkg;

   localparam int COUNT_WIDTH_DEF = 32;
   localparam int NUM_CH          = 4;
   localparam int NUM_SUBSETS     = 11;
   localparam int NUM_STEPS       = NUM_CH + NUM_SUBSETS;
   localparam int SGL_ADDR_W      = 2;
   localparam int SUB_ADDR_W      = 4;
   localparam int CSR_INDEX_W     = 8;
   localparam int REG_W           = 16;

   localparam logic [1:0] ACT_EDGE   = 2'd0;
   localparam logic [1:0] ACT_REPORT = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   localparam logic KIND_SINGLE = 1'b0;
   localparam logic KIND_SUBSET = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLDOFF = 8'd1;

   localparam logic [REG_W-1:0] WINDOW_RESET  = 16'd20;
   localparam logic [REG_W-1:0] HOLDOFF_RESET = 16'd20;

   typedef logic [3:0] mask_type;

   // multi-channel masks in report order
   localparam mask_type REPORT_MASKS [NUM_SUBSETS] = '{
      4'd3, 4'd5, 4'd9, 4'd6, 4'd10, 4'd12, 4'd7, 4'd11, 4'd13, 4'd14, 4'd15
   };

   typedef struct packed {
      logic rd_en;
      logic inc;
      logic clear;
   } bank_ctl_type;

   typedef struct packed {
      logic     kind;
      mask_type index;
      logic     last;
   } step_info_type;

   function automatic step_info_type report_step(input logic [3:0] step);
      step_info_type info;
      info = '0;
      if (step < 4'(NUM_CH)) begin
         info.kind  = KIND_SINGLE;
         info.index = step;
      end else if (step < 4'(NUM_STEPS)) begin
         info.kind  = KIND_SUBSET;
         info.index = REPORT_MASKS[step - 4'(NUM_CH)];
      end
      info.last = (step == 4'(NUM_STEPS - 1));
      return info;
   endfunction

endpackage

### sv/ccc_tally_bank.sv
// counter memory with read-modify-write increment, forwarding and valid bits
`timescale 1ns / 1ps

module ccc_tally_bank #(
   parameter int ADDR_W      = 2,
   parameter int COUNT_WIDTH = ccc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ccc_pkg::bank_ctl_type  ctl,
   input  logic [ADDR_W-1:0]      addr,
   output logic [COUNT_WIDTH-1:0] value
);
   import ccc_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   logic [COUNT_WIDTH-1:0] mem [DEPTH];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic [ADDR_W-1:0]      rd_addr_ff;
   logic                   inc_pend_ff;
   logic [DEPTH-1:0]       valid_ff, valid_in;
   logic                   wb_valid_ff, wb_valid_in;
   logic [ADDR_W-1:0]      wb_addr_ff;
   logic [COUNT_WIDTH-1:0] wb_data_ff;
   logic [COUNT_WIDTH-1:0] sum;

   // last write wins over the stale read; entries never written read as zero
   always_comb begin
      if (wb_valid_ff && (wb_addr_ff == rd_addr_ff)) begin
         value = wb_data_ff;
      end else if (valid_ff[rd_addr_ff]) begin
         value = rd_data_ff;
      end else begin
         value = '0;
      end
      sum = value + COUNT_WIDTH'(1);
   end

   always_comb begin
      valid_in    = valid_ff;
      wb_valid_in = wb_valid_ff | inc_pend_ff;
      if (inc_pend_ff) begin
         valid_in[rd_addr_ff] = 1'b1;
      end
      if (ctl.clear) begin
         valid_in    = '0;
         wb_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
         rd_addr_ff <= addr;
      end
      if (inc_pend_ff) begin
         mem[rd_addr_ff] <= sum;
         wb_addr_ff      <= rd_addr_ff;
         wb_data_ff      <= sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_pend_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
         valid_ff    <= '0;
      end else begin
         inc_pend_ff <= ctl.rd_en & ctl.inc;
         wb_valid_ff <= wb_valid_in;
         valid_ff    <= valid_in;
      end
   end

endmodule

### sv/coincidence_cluster_counter_unit.sv
// top level: cluster tracking, counter banks and report sequencer
// edge events: one per cycle while not reporting, state update at accept, counter write in the next cycle
// clear: counters and period zeroed; report: accepted, then 15 results, each read from a
//   registered counter memory; a new read issues only once the last result has landed and rsp can take it
// first report result: state moves to report, the counter read issues, the result is registered
// reset: synchronous; counters read as zero at once through valid bits, registers 20/20
`timescale 1ns / 1ps

module coincidence_cluster_counter_unit #(
   parameter int COUNT_WIDTH = ccc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [39:0]                     req_tdata,  // channel, timestamp, zero fill
   input  logic [1:0]                      req_tuser,  // action
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [71:0]                     rsp_tdata,  // period_number, counter_index,
                                                       // count_value, zero fill
   output logic                            rsp_tuser,  // counter_kind
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ccc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ccc_pkg::REG_W-1:0]       csr_data
);
   import ccc_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_REPORT = 1'b1;

   logic [REG_W-1:0] window_ff, holdoff_len_ff;
   logic             cl_open_ff, cl_open_in;
   logic [31:0]      cl_start_ff, cl_start_in;
   logic [31:0]      cl_end_ff, cl_end_in;
   logic [3:0]       cl_chan_ff, cl_chan_in;
   logic [31:0]      holdoff_end_ff, holdoff_end_in;
   logic [31:0]      period_ff, period_in;
   logic             state_ff, state_in;
   logic [3:0]       step_ff, step_in;
   logic             pend_ff, pend_in;
   step_info_type    tag_ff, tag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_period_ff;
   logic             rsp_kind_ff;
   logic [3:0]       rsp_index_ff;
   logic [31:0]      rsp_count_ff;
   logic             rsp_last_ff;

   bank_ctl_type            sgl_ctl, sub_ctl;
   logic [SGL_ADDR_W-1:0]   sgl_addr;
   logic [SUB_ADDR_W-1:0]   sub_addr;
   logic [COUNT_WIDTH-1:0]  sgl_value, sub_value, land_value;
   logic [63:0]             land_wide;

   logic          req_fire, issue, land;
   logic [1:0]    action, ch;
   logic [31:0]   ts, diff_hold, diff_start;
   logic [3:0]    ch_bit;
   logic          ignore, in_win;
   step_info_type step_info;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign action     = req_tuser;
   assign ch         = req_tdata[1:0];
   assign ts         = req_tdata[33:2];
   assign ch_bit     = 4'b0001 << ch;
   assign diff_hold  = ts - holdoff_end_ff;
   assign diff_start = ts - cl_start_ff;
   // signed wrap compare against the holdoff end
   assign ignore     = diff_hold[31];
   assign in_win     = (diff_start[15:0] <= window_ff);

   assign csr_ready  = 1'b1;

   assign step_info  = report_step(step_ff);
   assign issue      = (state_ff == ST_REPORT) && !pend_ff && (!rsp_valid_ff || rsp_tready);
   assign land       = pend_ff;
   assign land_value = (tag_ff.kind == KIND_SUBSET) ? sub_value : sgl_value;
   assign land_wide  = 64'(land_value);

   always_comb begin
      cl_open_in     = cl_open_ff;
      cl_start_in    = cl_start_ff;
      cl_end_in      = cl_end_ff;
      cl_chan_in     = cl_chan_ff;
      holdoff_end_in = holdoff_end_ff;
      period_in      = period_ff;
      state_in       = state_ff;
      step_in        = step_ff;
      pend_in        = 1'b0;
      tag_in         = tag_ff;
      sgl_ctl        = '0;
      sub_ctl        = '0;
      sgl_addr       = ch;
      sub_addr       = cl_chan_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (action)
                  ACT_EDGE: begin
                     sgl_ctl.rd_en = 1'b1;
                     sgl_ctl.inc   = 1'b1;
                     if (!ignore) begin
                        if (cl_open_ff && in_win) begin
                           cl_end_in  = ts;
                           cl_chan_in = cl_chan_ff | ch_bit;
                        end else begin
                           if (cl_open_ff) begin
                              // close the old cluster before the new one opens
                              sub_ctl.rd_en  = (cl_chan_ff != 4'd0);
                              sub_ctl.inc    = 1'b1;
                              holdoff_end_in = cl_end_ff + 32'(holdoff_len_ff);
                           end
                           cl_open_in  = 1'b1;
                           cl_start_in = ts;
                           cl_end_in   = ts;
                           cl_chan_in  = ch_bit;
                        end
                     end
                  end
                  ACT_REPORT: begin
                     sub_ctl.rd_en  = cl_open_ff && (cl_chan_ff != 4'd0);
                     sub_ctl.inc    = 1'b1;
                     cl_open_in     = 1'b0;
                     cl_chan_in     = 4'd0;
                     holdoff_end_in = '0;
                     state_in       = ST_REPORT;
                     step_in        = 4'd0;
                  end
                  ACT_CLEAR: begin
                     sgl_ctl.clear  = 1'b1;
                     sub_ctl.clear  = 1'b1;
                     cl_open_in     = 1'b0;
                     cl_chan_in     = 4'd0;
                     holdoff_end_in = '0;
                     period_in      = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_REPORT: begin
            if (issue) begin
               pend_in = 1'b1;
               tag_in  = step_info;
               step_in = step_ff + 4'd1;
               if (step_info.kind == KIND_SUBSET) begin
                  sub_ctl.rd_en = 1'b1;
                  sub_addr      = step_info.index;
               end else begin
                  sgl_ctl.rd_en = 1'b1;
                  sgl_addr      = step_info.index[SGL_ADDR_W-1:0];
               end
            end
            if (land) begin
               rsp_valid_in = 1'b1;
               if (tag_ff.last) begin
                  sgl_ctl.clear = 1'b1;
                  sub_ctl.clear = 1'b1;
                  period_in     = period_ff + 32'd1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= WINDOW_RESET;
         holdoff_len_ff <= HOLDOFF_RESET;
         cl_open_ff     <= 1'b0;
         cl_start_ff    <= '0;
         cl_end_ff      <= '0;
         cl_chan_ff     <= '0;
         holdoff_end_ff <= '0;
         period_ff      <= '0;
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == CSR_WINDOW)) begin
            window_ff <= csr_data;
         end
         if (csr_valid && (csr_index == CSR_HOLDOFF)) begin
            holdoff_len_ff <= csr_data;
         end
         cl_open_ff     <= cl_open_in;
         cl_start_ff    <= cl_start_in;
         cl_end_ff      <= cl_end_in;
         cl_chan_ff     <= cl_chan_in;
         holdoff_end_ff <= holdoff_end_in;
         period_ff      <= period_in;
         state_ff       <= state_in;
         step_ff        <= step_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      if (land) begin
         rsp_period_ff <= period_ff;
         rsp_kind_ff   <= tag_ff.kind;
         rsp_index_ff  <= tag_ff.index;
         rsp_count_ff  <= land_wide[31:0];
         rsp_last_ff   <= tag_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_count_ff, rsp_index_ff, rsp_period_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   ccc_tally_bank #(
      .ADDR_W      (SGL_ADDR_W),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_singles (
      .clock (clock),
      .reset (reset),
      .ctl   (sgl_ctl),
      .addr  (sgl_addr),
      .value (sgl_value)
   );

   ccc_tally_bank #(
      .ADDR_W      (SUB_ADDR_W),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_subsets (
      .clock (clock),
      .reset (reset),
      .ctl   (sub_ctl),
      .addr  (sub_addr),
      .value (sub_value)
   );

endmodule
